// ----- rtl/core/eap_pkg.sv -----
// ----------------------------------------------------------------------------
// eap_pkg: ellipse axis projection shared types and constants
// Fixed-point widths, payload structs, register indexes and saturation.
// ----------------------------------------------------------------------------
package eap_pkg;

  localparam int COORD_W  = 24;
  localparam int SQ_EXTRA = (COORD_W < 32) ? (32 - COORD_W) : 0;
  localparam int DIAM_W   = COORD_W - 1;           // box width / height
  localparam int OFFS_W   = COORD_W + 3;           // doubled offset from center
  localparam int EXT_W    = COORD_W + 2;           // output math before saturation
  localparam int SQRT_W   = DIAM_W + SQ_EXTRA;     // root bits, one per cell
  localparam int RAD_W    = 2 * SQRT_W;
  localparam int PROD_W   = DIAM_W + SQRT_W;
  localparam int NUM_W    = PROD_W + 1;
  localparam int QUOT_W   = DIAM_W;                // quotient bits, one per cell
  localparam int DEN_W    = NUM_W - QUOT_W;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_BOX_LEFT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_BOTTOM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_HEIGHT = 2'd3;

  localparam logic signed [EXT_W-1:0] SAT_HI = EXT_W'((64'sd1 <<< (COORD_W - 1)) - 64'sd1);
  localparam logic signed [EXT_W-1:0] SAT_LO = -SAT_HI - EXT_W'(1);

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic                      along_horizontal;
  } query_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] near_x;
    logic signed [COORD_W-1:0] near_y;
    logic signed [COORD_W-1:0] offset_dx;
    logic signed [COORD_W-1:0] offset_dy;
  } result_t;

  // per-item info carried down the whole pipe
  typedef struct packed {
    logic                     horiz;
    logic                     pole_pos;
    logic                     pole_neg;
    logic                     sneg;      // solved-axis offset negative
    logic signed [OFFS_W-1:0] kr;        // doubled kept-axis offset
    logic signed [COORD_W-1:0] kp;       // kept query coordinate
  } tag_t;

  typedef struct packed {
    tag_t              tag;
    logic [RAD_W-1:0]  rad;
    logic [SQRT_W+1:0] rem;
    logic [SQRT_W-1:0] root;
  } sq_t;

  typedef struct packed {
    tag_t              tag;
    logic [QUOT_W-1:0] nlow;
    logic [DEN_W-1:0]  rem;
    logic [QUOT_W-1:0] quot;
  } dv_t;

  function automatic logic signed [COORD_W-1:0] sat(input logic signed [EXT_W-1:0] v);
    logic signed [EXT_W-1:0] c;
    c = v;
    if (v > SAT_HI) c = SAT_HI;
    else if (v < SAT_LO) c = SAT_LO;
    return c[COORD_W-1:0];
  endfunction

endpackage

// ----- rtl/core/eap_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// eap_sqrt_cell: one digit of the restoring square root
// Takes two radicand bits, decides one root bit, registers the item.
// ----------------------------------------------------------------------------
module eap_sqrt_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  eap_pkg::sq_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output eap_pkg::sq_t  out_data
);

  eap_pkg::sq_t               data_next;
  logic [eap_pkg::SQRT_W+1:0] rem2;
  logic [eap_pkg::SQRT_W+1:0] trial;
  logic                       ge;

  always_comb begin
    rem2  = {in_data.rem[eap_pkg::SQRT_W-1:0], in_data.rad[eap_pkg::RAD_W-1 -: 2]};
    trial = {in_data.root, 2'b01};
    ge    = (rem2 >= trial);
    data_next      = in_data;
    data_next.rad  = in_data.rad << 2;
    data_next.rem  = ge ? (rem2 - trial) : rem2;
    data_next.root = {in_data.root[eap_pkg::SQRT_W-2:0], ge};
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

// ----- rtl/core/eap_div_cell.sv -----
// ----------------------------------------------------------------------------
// eap_div_cell: one quotient bit of the restoring divider
// Shifts in one numerator bit, compares against the divisor, registers.
// ----------------------------------------------------------------------------
module eap_div_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [eap_pkg::DEN_W-1:0]   den_h,
  input  logic [eap_pkg::DEN_W-1:0]   den_v,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  eap_pkg::dv_t                in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output eap_pkg::dv_t                out_data
);

  eap_pkg::dv_t              data_next;
  logic [eap_pkg::DEN_W-1:0] den;
  logic [eap_pkg::DEN_W:0]   rem2;
  logic                      ge;

  always_comb begin
    // divisor is the kept-axis diameter, scaled
    den  = in_data.tag.horiz ? den_h : den_v;
    rem2 = {in_data.rem, in_data.nlow[eap_pkg::QUOT_W-1]};
    ge   = (rem2 >= {1'b0, den});
    data_next      = in_data;
    data_next.nlow = in_data.nlow << 1;
    data_next.rem  = ge ? eap_pkg::DEN_W'(rem2 - {1'b0, den})
                        : rem2[eap_pkg::DEN_W-1:0];
    data_next.quot = {in_data.quot[eap_pkg::QUOT_W-2:0], ge};
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

// ----- rtl/core/ellipse_axis_projection_top.sv -----
// ----------------------------------------------------------------------------
// ellipse_axis_projection_top: projects a point onto the box's ellipse
// Front stages, a chain of square-root cells, multiply/add stages, a chain
// of divider cells and a registered output stage.
// ----------------------------------------------------------------------------
// Usage:
//   query channel (query_valid/query_ready/query) carries point_x, point_y and
//   along_horizontal; result channel (result_valid/result_ready/result) returns
//   exactly one result per query, in order.
//   The box registers take one write per cycle through cfg_we/cfg_index/cfg_data;
//   the user must write them only while no query is in flight (not enforced).
//   A query passes through 3 front stages, SQRT_W = 31 square-root cells
//   (one root bit each), 2 multiply/add stages, QUOT_W = 23 divider cells
//   (one quotient bit each) and the output register. Throughput is one query
//   per cycle while results are taken; every stage holds its own item.
//   When the receiver stalls, the stalled result stays in the output register
//   and the upstream stages keep filling bubbles; query_ready drops only when
//   every stage is occupied.
//   Reset clears all valid bits and sets the box registers to zero.
// ----------------------------------------------------------------------------
module ellipse_axis_projection_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [eap_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [eap_pkg::COORD_W-1:0]         cfg_data,
  input  logic                                query_valid,
  output logic                                query_ready,
  input  eap_pkg::query_t                     query,
  output logic                                result_valid,
  input  logic                                result_ready,
  output eap_pkg::result_t                    result
);

  localparam int W  = eap_pkg::COORD_W;
  localparam int SW = eap_pkg::SQRT_W;
  localparam int QW = eap_pkg::QUOT_W;

  typedef struct packed {
    eap_pkg::tag_t                  tag;
    logic [2*eap_pkg::DIAM_W-1:0]   kk;
    logic [2*eap_pkg::DIAM_W-1:0]   dd;
  } sqr_t;

  typedef struct packed {
    eap_pkg::tag_t                  tag;
    logic [eap_pkg::PROD_W-1:0]     prod;
  } mul_t;

  // box registers
  logic signed [W-1:0]           box_left;
  logic signed [W-1:0]           box_bottom;
  logic [eap_pkg::DIAM_W-1:0]    box_width;
  logic [eap_pkg::DIAM_W-1:0]    box_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_left   <= '0;
      box_bottom <= '0;
      box_width  <= '0;
      box_height <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        eap_pkg::REG_BOX_LEFT:   box_left   <= cfg_data;
        eap_pkg::REG_BOX_BOTTOM: box_bottom <= cfg_data;
        eap_pkg::REG_BOX_WIDTH:  box_width  <= cfg_data[eap_pkg::DIAM_W-1:0];
        eap_pkg::REG_BOX_HEIGHT: box_height <= cfg_data[eap_pkg::DIAM_W-1:0];
        default: ;
      endcase
    end
  end

  logic [eap_pkg::DEN_W-1:0] den_h;
  logic [eap_pkg::DEN_W-1:0] den_v;
  assign den_h = eap_pkg::DEN_W'(box_height) << (eap_pkg::SQ_EXTRA + 1);
  assign den_v = eap_pkg::DEN_W'(box_width) << (eap_pkg::SQ_EXTRA + 1);

  // ---------------- stage A: offsets and pole tests ----------------
  logic                               a_v, a_rdy;
  eap_pkg::tag_t                      a_d, a_next;
  logic signed [eap_pkg::OFFS_W-1:0]  rx2, ry2, kr_a, sr_a, kd_a;
  logic                               b_rdy;

  always_comb begin
    rx2 = {{2{query.point_x[W-1]}}, query.point_x, 1'b0}
        - {{2{box_left[W-1]}}, box_left, 1'b0}
        - eap_pkg::OFFS_W'(box_width);
    ry2 = {{2{query.point_y[W-1]}}, query.point_y, 1'b0}
        - {{2{box_bottom[W-1]}}, box_bottom, 1'b0}
        - eap_pkg::OFFS_W'(box_height);
    kr_a = query.along_horizontal ? ry2 : rx2;
    sr_a = query.along_horizontal ? rx2 : ry2;
    kd_a = eap_pkg::OFFS_W'(query.along_horizontal ? box_height : box_width);
    a_next.horiz    = query.along_horizontal;
    a_next.pole_pos = (kr_a >= kd_a);
    a_next.pole_neg = !(kr_a >= kd_a) && (kr_a <= -kd_a);
    a_next.sneg     = sr_a[eap_pkg::OFFS_W-1];
    a_next.kr       = kr_a;
    a_next.kp       = query.along_horizontal ? query.point_y : query.point_x;
  end

  assign a_rdy       = !a_v || b_rdy;
  assign query_ready = a_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (a_rdy) begin
      a_v <= query_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_rdy && query_valid) begin
      a_d <= a_next;
    end
  end

  // ---------------- stage B: squares ----------------
  logic                               b_v;
  sqr_t                               b_d, b_next;
  logic signed [eap_pkg::OFFS_W-1:0]  kr_abs;
  logic [eap_pkg::DIAM_W-1:0]         ad_b, kd_b;
  logic                               c_rdy;

  always_comb begin
    kr_abs = a_d.kr[eap_pkg::OFFS_W-1] ? -a_d.kr : a_d.kr;
    ad_b   = kr_abs[eap_pkg::DIAM_W-1:0];
    kd_b   = a_d.horiz ? box_height : box_width;
    b_next.tag = a_d;
    b_next.kk  = kd_b * kd_b;
    b_next.dd  = ad_b * ad_b;
  end

  assign b_rdy = !b_v || c_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else if (b_rdy) begin
      b_v <= a_v;
    end
  end

  always_ff @(posedge clk) begin
    if (b_rdy && a_v) begin
      b_d <= b_next;
    end
  end

  // ---------------- stage C: radicand ----------------
  logic          sq_v   [0:SW];
  logic          sq_rdy [0:SW];
  eap_pkg::sq_t  sq_d   [0:SW];
  eap_pkg::sq_t  c_next;

  always_comb begin
    c_next.tag  = b_d.tag;
    c_next.rad  = {b_d.kk - b_d.dd, {(2*eap_pkg::SQ_EXTRA){1'b0}}};
    c_next.rem  = '0;
    c_next.root = '0;
  end

  assign c_rdy = !sq_v[0] || sq_rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v[0] <= 1'b0;
    end else if (c_rdy) begin
      sq_v[0] <= b_v;
    end
  end

  always_ff @(posedge clk) begin
    if (c_rdy && b_v) begin
      sq_d[0] <= c_next;
    end
  end

  // ---------------- square-root chain ----------------
  for (genvar i = 0; i < SW; i++) begin : g_sqrt
    eap_sqrt_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (sq_v[i]),
      .in_ready  (sq_rdy[i]),
      .in_data   (sq_d[i]),
      .out_valid (sq_v[i+1]),
      .out_ready (sq_rdy[i+1]),
      .out_data  (sq_d[i+1])
    );
  end

  // ---------------- stage M: solved diameter times root ----------------
  logic                        m_v, m_rdy;
  mul_t                        m_d, m_next;
  logic [eap_pkg::DIAM_W-1:0]  sd_m;
  logic                        n_rdy;

  always_comb begin
    sd_m        = sq_d[SW].tag.horiz ? box_width : box_height;
    m_next.tag  = sq_d[SW].tag;
    m_next.prod = sd_m * sq_d[SW].root;
  end

  assign m_rdy      = !m_v || n_rdy;
  assign sq_rdy[SW] = m_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_v <= 1'b0;
    end else if (m_rdy) begin
      m_v <= sq_v[SW];
    end
  end

  always_ff @(posedge clk) begin
    if (m_rdy && sq_v[SW]) begin
      m_d <= m_next;
    end
  end

  // ---------------- stage N: rounding bias, divider setup ----------------
  logic                        dv_v   [0:QW];
  logic                        dv_rdy [0:QW];
  eap_pkg::dv_t                dv_d   [0:QW];
  eap_pkg::dv_t                n_next;
  logic [eap_pkg::NUM_W-1:0]   num;
  logic [eap_pkg::DIAM_W-1:0]  kd_n;

  always_comb begin
    kd_n = m_d.tag.horiz ? box_height : box_width;
    num  = eap_pkg::NUM_W'(m_d.prod)
         + (eap_pkg::NUM_W'(kd_n) << eap_pkg::SQ_EXTRA);
    n_next.tag  = m_d.tag;
    n_next.nlow = num[QW-1:0];
    n_next.rem  = num[eap_pkg::NUM_W-1:QW];
    n_next.quot = '0;
  end

  assign n_rdy = !dv_v[0] || dv_rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else if (n_rdy) begin
      dv_v[0] <= m_v;
    end
  end

  always_ff @(posedge clk) begin
    if (n_rdy && m_v) begin
      dv_d[0] <= n_next;
    end
  end

  // ---------------- divider chain ----------------
  for (genvar j = 0; j < QW; j++) begin : g_div
    eap_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .den_h     (den_h),
      .den_v     (den_v),
      .in_valid  (dv_v[j]),
      .in_ready  (dv_rdy[j]),
      .in_data   (dv_d[j]),
      .out_valid (dv_v[j+1]),
      .out_ready (dv_rdy[j+1]),
      .out_data  (dv_d[j+1])
    );
  end

  // ---------------- stage O: assemble and saturate ----------------
  logic                               o_rdy;
  eap_pkg::tag_t                      tg;
  eap_pkg::result_t                   o_next;
  logic signed [eap_pkg::EXT_W-1:0]   se, sd, ke, kd;
  logic signed [eap_pkg::EXT_W-1:0]   center, khalf, mag;
  logic signed [eap_pkg::EXT_W-1:0]   s_off, s_near, k_off, k_near;
  logic signed [eap_pkg::OFFS_W-1:0]  ka, kah;

  always_comb begin
    tg     = dv_d[QW].tag;
    se     = eap_pkg::EXT_W'(tg.horiz ? box_left : box_bottom);
    ke     = eap_pkg::EXT_W'(tg.horiz ? box_bottom : box_left);
    sd     = eap_pkg::EXT_W'(tg.horiz ? box_width : box_height);
    kd     = eap_pkg::EXT_W'(tg.horiz ? box_height : box_width);
    center = ((se <<< 1) + sd + eap_pkg::EXT_W'(1)) >>> 1;
    khalf  = (kd + eap_pkg::EXT_W'(1)) >>> 1;
    mag    = eap_pkg::EXT_W'(dv_d[QW].quot);
    ka     = tg.kr[eap_pkg::OFFS_W-1] ? -tg.kr : tg.kr;
    kah    = (ka + eap_pkg::OFFS_W'(1)) >>> 1;
    if (tg.pole_pos) begin
      s_off  = '0;
      s_near = center;
      k_off  = khalf;
      k_near = ke + kd;
    end else if (tg.pole_neg) begin
      s_off  = '0;
      s_near = center;
      k_off  = -khalf;
      k_near = ke;
    end else begin
      s_off  = tg.sneg ? -mag : mag;
      s_near = center + s_off;
      k_off  = tg.kr[eap_pkg::OFFS_W-1] ? -eap_pkg::EXT_W'(kah) : eap_pkg::EXT_W'(kah);
      k_near = eap_pkg::EXT_W'(tg.kp);
    end
    if (tg.horiz) begin
      o_next.near_x    = eap_pkg::sat(s_near);
      o_next.offset_dx = eap_pkg::sat(s_off);
      o_next.near_y    = eap_pkg::sat(k_near);
      o_next.offset_dy = eap_pkg::sat(k_off);
    end else begin
      o_next.near_x    = eap_pkg::sat(k_near);
      o_next.offset_dx = eap_pkg::sat(k_off);
      o_next.near_y    = eap_pkg::sat(s_near);
      o_next.offset_dy = eap_pkg::sat(s_off);
    end
  end

  assign o_rdy      = !result_valid || result_ready;
  assign dv_rdy[QW] = o_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (o_rdy) begin
      result_valid <= dv_v[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (o_rdy && dv_v[QW]) begin
      result <= o_next;
    end
  end

`ifndef NO_ASSERTIONS
  // a transfer always lands in the first stage
  ap_fill: assert property (@(posedge clk) disable iff (rst)
    query_valid && query_ready |=> a_v)
    else $error("query transfer lost at stage A");

  // backpressure reaches the input only when the output holds a result
  ap_stall: assert property (@(posedge clk) disable iff (rst)
    !query_ready |-> result_valid && !result_ready)
    else $error("query stalled with output free");

  // finished root leaves a remainder no larger than twice the root
  ap_root: assert property (@(posedge clk) disable iff (rst)
    sq_v[SW] && !sq_d[SW].tag.pole_pos && !sq_d[SW].tag.pole_neg
    |-> sq_d[SW].rem <= {1'b0, sq_d[SW].root, 1'b0})
    else $error("square root remainder out of range");

  // finished division leaves a remainder below the divisor
  ap_div: assert property (@(posedge clk) disable iff (rst)
    dv_v[QW] && !dv_d[QW].tag.pole_pos && !dv_d[QW].tag.pole_neg
    |-> dv_d[QW].rem < (dv_d[QW].tag.horiz ? den_h : den_v))
    else $error("divider remainder out of range");

  ap_reset: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result valid right after reset");
`endif

endmodule

// ----- sim/tb_ellipse_axis_projection_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ellipse_axis_projection_top: ellipse axis projection testbench
// Drives query points against several box settings. The scoreboard predicts
// each projection in fixed point and checks results in order. Both channels
// idle at random, and one long receiver stall backs up the pipe.
// ----------------------------------------------------------------------------
module tb_ellipse_axis_projection_top;

  class proj_scoreboard;
    longint box_l, box_b, box_w, box_h;
    eap_pkg::result_t pending[$];
    int      errors;
    int      checked;
    int      poles;

    function void set_box(longint l, longint b, longint w, longint h);
      box_l = l; box_b = b; box_w = w; box_h = h;
    endfunction

    static function longint clamp(longint v);
      if (v > 8388607) return 8388607;
      if (v < -8388608) return -8388608;
      return v;
    endfunction

    static function longint half_away(longint v);
      return v >= 0 ? (v + 1) / 2 : -((-v + 1) / 2);
    endfunction

    static function longint half_up(longint v);
      longint t;
      t = v + 1;
      return t >= 0 ? t / 2 : -((-t + 1) / 2);
    endfunction

    static function longint unsigned root64(longint unsigned n);
      longint unsigned r, bitv;
      r = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
        if (n >= r + bitv) begin
          n -= r + bitv;
          r = (r >> 1) + bitv;
        end else begin
          r >>= 1;
        end
        bitv >>= 2;
      end
      return r;
    endfunction

    // kept axis: edge ke, diameter kd, point kp, doubled offset kr
    function void project_axis(input longint ke, kd, kp, kr, se, sd, sr,
                               output longint kn, ko, sn, so);
      longint ctr, mag;
      longint unsigned ad, q, s;
      ctr = half_up(2 * se + sd);
      if (kr >= kd) begin
        so = 0; sn = ctr; ko = (kd + 1) / 2; kn = ke + kd; poles++;
      end else if (kr <= -kd) begin
        so = 0; sn = ctr; ko = -((kd + 1) / 2); kn = ke; poles++;
      end else begin
        ad = kr < 0 ? -kr : kr;
        q = kd * kd - ad * ad;
        s = root64(q << (2 * eap_pkg::SQ_EXTRA));
        mag = (sd * s + (kd << eap_pkg::SQ_EXTRA)) / ((2 * kd) << eap_pkg::SQ_EXTRA);
        so = sr < 0 ? -mag : mag;
        sn = ctr + so;
        ko = half_away(kr);
        kn = kp;
      end
    endfunction

    function void note_query(eap_pkg::query_t qi);
      longint px, py, rx2, ry2, nx, ny, ox, oy;
      eap_pkg::result_t r;
      px = qi.point_x;
      py = qi.point_y;
      rx2 = 2 * px - (2 * box_l + box_w);
      ry2 = 2 * py - (2 * box_b + box_h);
      if (qi.along_horizontal)
        project_axis(box_b, box_h, py, ry2, box_l, box_w, rx2, ny, oy, nx, ox);
      else
        project_axis(box_l, box_w, px, rx2, box_b, box_h, ry2, nx, ox, ny, oy);
      r.near_x = eap_pkg::COORD_W'(clamp(nx));
      r.near_y = eap_pkg::COORD_W'(clamp(ny));
      r.offset_dx = eap_pkg::COORD_W'(clamp(ox));
      r.offset_dy = eap_pkg::COORD_W'(clamp(oy));
      pending.push_back(r);
    endfunction

    task check_result(eap_pkg::result_t got);
      eap_pkg::result_t e;
      if (pending.size() == 0) begin
        report("unexpected result", 0, got.near_x);
        return;
      end
      e = pending.pop_front();
      checked++;
      if (got.near_x !== e.near_x) report("near_x", e.near_x, got.near_x);
      if (got.near_y !== e.near_y) report("near_y", e.near_y, got.near_y);
      if (got.offset_dx !== e.offset_dx) report("offset_dx", e.offset_dx, got.offset_dx);
      if (got.offset_dy !== e.offset_dy) report("offset_dy", e.offset_dy, got.offset_dy);
    endtask

    task report(string what, longint exp_v, longint got_v);
      errors++;
      $display("MISMATCH %s after %0d results: expected %0d got %0d",
               what, checked, exp_v, got_v);
    endtask
  endclass

  logic                          clk = 0;
  logic                          rst = 1;
  logic                          cfg_we = 0;
  logic [eap_pkg::CFG_IDX_W-1:0] cfg_index = eap_pkg::REG_BOX_LEFT;
  logic [eap_pkg::COORD_W-1:0]   cfg_data = '0;
  logic                          query_valid = 0;
  logic                          query_ready;
  eap_pkg::query_t               query = '0;
  logic                          result_valid;
  logic                          result_ready = 0;
  eap_pkg::result_t              result;

  proj_scoreboard sb;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_off_cycles = 0;
  int quiet_cycles = 0;
  int sent = 0;

  localparam int WATCHDOG = 20000;
  localparam int HOLD_OFF = 200;

  ellipse_axis_projection_top dut (.*);

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  // receiver: random stalls plus an optional long hold-off
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && result_ready) sb.check_result(result);
      if (hold_req != hold_seen) begin
        hold_seen <= hold_req;
        hold_off_cycles <= HOLD_OFF;
        result_ready <= 1'b0;
      end else if (hold_off_cycles > 0) begin
        hold_off_cycles <= hold_off_cycles - 1;
        result_ready <= 1'b0;
      end else begin
        result_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((query_valid && query_ready) || (result_valid && result_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("Timeout: no transfer for %0d cycles", WATCHDOG);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic write_reg(logic [eap_pkg::CFG_IDX_W-1:0] idx, longint v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v[eap_pkg::COORD_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_box(longint l, longint b, longint w, longint h);
    write_reg(eap_pkg::REG_BOX_LEFT, l);
    write_reg(eap_pkg::REG_BOX_BOTTOM, b);
    write_reg(eap_pkg::REG_BOX_WIDTH, w);
    write_reg(eap_pkg::REG_BOX_HEIGHT, h);
    sb.set_box(l, b, w, h);
  endtask

  // valid stays up between back-to-back transfers; it drops only while idling
  task automatic send_query(longint x, longint y, bit horiz);
    eap_pkg::query_t qi;
    while ($urandom_range(99) < send_idle_pct) begin
      query_valid <= 1'b0;
      @(posedge clk);
    end
    qi.point_x = x[eap_pkg::COORD_W-1:0];
    qi.point_y = y[eap_pkg::COORD_W-1:0];
    qi.along_horizontal = horiz;
    query <= qi;
    query_valid <= 1'b1;
    do @(posedge clk); while (!query_ready);
    sb.note_query(qi);
    sent++;
  endtask

  task automatic drain();
    query_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (70) @(posedge clk);
  endtask

  // random point: mostly near the box, sometimes anywhere
  task automatic random_query();
    longint x, y, cx, cy;
    cx = sb.box_l + sb.box_w / 2;
    cy = sb.box_b + sb.box_h / 2;
    if ($urandom_range(9) < 7) begin
      x = cx + $signed($urandom_range(2 * sb.box_w + 2)) - sb.box_w - 1;
      y = cy + $signed($urandom_range(2 * sb.box_h + 2)) - sb.box_h - 1;
      x = sb.clamp(x);
      y = sb.clamp(y);
    end else begin
      x = $signed(24'($urandom));
      y = $signed(24'($urandom));
    end
    send_query(x, y, 1'($urandom_range(1)));
  endtask

  task automatic random_box();
    longint w, h;
    w = ($urandom_range(3) == 0) ? $urandom_range(8388607) : $urandom_range(5000);
    h = ($urandom_range(3) == 0) ? $urandom_range(8388607) : $urandom_range(5000);
    set_box($signed(24'($urandom)) >>> $urandom_range(12),
            $signed(24'($urandom)) >>> $urandom_range(12), w, h);
  endtask

  initial begin
    sb = new();
    sb.set_box(0, 0, 0, 0);
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // degenerate reset box, then extremes
    send_query(0, 0, 1);
    send_query(0, 0, 0);
    send_query(8388607, -8388608, 1);
    drain();
    set_box(-8388608, -8388608, 8388607, 8388607);
    send_query(8388607, 8388607, 1);
    send_query(-8388608, -8388608, 0);
    send_query(0, 0, 1);
    send_query(0, 0, 0);
    send_query(-1, 0, 1);
    drain();
    set_box(8388607, 8388607, 8388607, 8388607);
    send_query(-8388608, 8388607, 0);
    send_query(8388607, -8388608, 1);
    drain();
    set_box(-256, -512, 512, 1024);
    send_query(0, 0, 1);
    send_query(100, 512, 1);
    send_query(-100, -512, 1);
    send_query(256, 10, 0);
    send_query(-256, -10, 0);
    send_query(300, 0, 0);
    send_query(-1, 1, 1);
    send_query(5, 511, 1);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 36 : (ph == 1) ? 58 : 0;
      recv_idle_pct = (ph == 0) ? 58 : (ph == 1) ? 36 : 0;
      for (int s = 0; s < 4; s++) begin
        if (ph == 2 && s == 0) set_box(-8388608, 8388607, 0, 8388607);
        else random_box();
        if (ph == 1 && s == 1) hold_req++;
        for (int i = 0; i < 103; i++) random_query();
        drain();
      end
    end

    $display("Ran %0d queries over several boxes, %0d pole cases, %0d results checked",
             sent, sb.poles, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
